/* rtl/core/arpc_pkg.sv */
// Shared types and constants for the ARP cache and responder.
// Used by arpc_cache, arpc_ctrl and arp_cache_responder_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package arpc_pkg;

  // Default sizes
  localparam int CACHE_DEPTH = 16;
  localparam int NUM_PORTS   = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_PORT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PORT0_IP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PORT0_MAC  = 3'd2;
  localparam int                   REG_STRIDE     = 2;

  localparam logic [1:0] PORT_COUNT_RESET = 2'd1;

  // Commands
  localparam logic [1:0] CMD_RESOLVE = 2'd0;
  localparam logic [1:0] CMD_REQUEST = 2'd1;
  localparam logic [1:0] CMD_REPLY   = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_HIT   = 3'd0;
  localparam logic [2:0] KIND_REQ   = 3'd1;
  localparam logic [2:0] KIND_REPLY = 3'd2;
  localparam logic [2:0] KIND_MISS  = 3'd3;
  localparam logic [2:0] KIND_NONE  = 3'd4;

  localparam logic [47:0] MAC_BCAST = 48'hffff_ffff_ffff;

  // Input word
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] query_ip;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [1:0]  in_port;
  } in_t;

  // Result word
  typedef struct packed {
    logic [2:0]  kind;
    logic        last;
    logic [1:0]  out_port;
    logic [47:0] eth_dst_mac;
    logic [47:0] arp_src_mac;
    logic [31:0] arp_src_ip;
    logic [47:0] arp_dst_mac;
    logic [31:0] arp_dst_ip;
    logic [47:0] resolved_mac;
  } out_t;

  // Cache write request
  typedef struct packed {
    logic        en;
    logic [31:0] ip;
    logic [47:0] mac;
  } cache_wr_t;

  // Search status back to the sequencer
  typedef struct packed {
    logic        done;
    logic        hit;
    logic [47:0] mac;
  } srch_t;

endpackage

`default_nettype wire

/* rtl/core/arp_cache_responder_top.sv */
// Top level of the ARP cache and responder: configuration registers and
// the sequencer/cache pair. Depends on arpc_pkg, arpc_cache and arpc_ctrl.
`timescale 1ns / 1ps
`default_nettype none

// A command is taken when start is high and busy is low. At most one
// word per cycle comes on result, each marked by result_valid for exactly one
// cycle; the receiver cannot stall, so it must take every word as it comes.
// The final word of a command has last set. A received reply, an unknown
// command or a request on an absent port gives its one word the cycle after
// it is taken and leaves busy low. A resolve or a served request searches
// the cache newest first through one compare unit, one entry per cycle.
// After a full miss the ports are walked: a resolve walks every present
// port and ends with a miss word, a request stops at the port that
// answers and ends with a no-action word when none does. Cache contents are
// undefined after reset; per-entry valid bits are cleared by reset, so no
// clearing pass runs. Configuration must be written only while idle, through
// cfg_we/cfg_index/cfg_data; the block itself does not enforce this.
module arp_cache_responder_top #(
  parameter int CACHE_DEPTH = arpc_pkg::CACHE_DEPTH,
  parameter int NUM_PORTS   = arpc_pkg::NUM_PORTS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire arpc_pkg::in_t                  item,
  output logic                                busy,
  output logic                                result_valid,
  output arpc_pkg::out_t                      result,
  input  wire logic                           cfg_we,
  input  wire logic [arpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [1:0]  port_count;
  logic [31:0] port_ip  [NUM_PORTS];
  logic [47:0] port_mac [NUM_PORTS];

  logic                srch_go;
  logic [31:0]         srch_key;
  arpc_pkg::srch_t     srch;
  arpc_pkg::cache_wr_t wr;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      port_count <= arpc_pkg::PORT_COUNT_RESET;
      for (int p = 0; p < NUM_PORTS; p++) begin
        port_ip[p]  <= '0;
        port_mac[p] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == arpc_pkg::REG_PORT_COUNT) begin
        port_count <= cfg_data[1:0];
      end
      for (int p = 0; p < NUM_PORTS; p++) begin
        if (cfg_index == arpc_pkg::REG_PORT0_IP
                         + arpc_pkg::CFG_IDX_W'(arpc_pkg::REG_STRIDE * p)) begin
          port_ip[p] <= cfg_data[31:0];
        end
        if (cfg_index == arpc_pkg::REG_PORT0_MAC
                         + arpc_pkg::CFG_IDX_W'(arpc_pkg::REG_STRIDE * p)) begin
          port_mac[p] <= cfg_data[47:0];
        end
      end
    end
  end

  arpc_ctrl #(
    .NUM_PORTS(NUM_PORTS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .busy         (busy),
    .port_count   (port_count),
    .port_ip      (port_ip),
    .port_mac     (port_mac),
    .srch_go      (srch_go),
    .srch_key     (srch_key),
    .srch         (srch),
    .wr           (wr),
    .result_valid (result_valid),
    .result       (result)
  );

  arpc_cache #(
    .CACHE_DEPTH(CACHE_DEPTH)
  ) u_cache (
    .clk  (clk),
    .rst  (rst),
    .go   (srch_go),
    .key  (srch_key),
    .wr   (wr),
    .srch (srch)
  );

endmodule

`default_nettype wire

/* rtl/core/arpc_cache.sv */
// Binding cache: ring memory of IP/MAC entries with a one-entry-per-cycle
// compare unit searching newest first. Depends on arpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arpc_cache #(
  parameter int CACHE_DEPTH = arpc_pkg::CACHE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                go,
  input  wire logic [31:0]         key,
  input  wire arpc_pkg::cache_wr_t wr,
  output arpc_pkg::srch_t          srch
);

  localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(CACHE_DEPTH - 1);

  logic [31:0]            mem_ip  [CACHE_DEPTH];
  logic [47:0]            mem_mac [CACHE_DEPTH];
  logic [CACHE_DEPTH-1:0] valid;

  logic [AW-1:0] ptr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] issue_cnt;
  logic          srch_on;
  logic          cmp_on;
  logic          cmp_last;
  logic [31:0]   key_q;
  logic [31:0]   rd_ip;
  logic [47:0]   rd_mac;
  logic          rd_v;
  logic          srch_done;
  logic          srch_hit;
  logic [47:0]   srch_mac;

  logic [AW-1:0] ptr_inc;
  logic [AW-1:0] ptr_dec;
  logic [AW-1:0] rd_addr_dec;
  logic          hit;
  logic          finish;

  // Ring arithmetic, also for depths that are not a power of two
  assign ptr_inc     = (ptr == LAST_IDX) ? '0 : ptr + AW'(1);
  assign ptr_dec     = (ptr == '0) ? LAST_IDX : ptr - AW'(1);
  assign rd_addr_dec = (rd_addr == '0) ? LAST_IDX : rd_addr - AW'(1);

  // Compare stage
  assign hit    = cmp_on && rd_v && (rd_ip == key_q);
  assign finish = cmp_on && (hit || cmp_last);

  // Write port at the insert pointer
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_ip[ptr]  <= wr.ip;
      mem_mac[ptr] <= wr.mac;
    end
  end

  // Registered read, key capture and hit data
  always_ff @(posedge clk) begin
    rd_ip  <= mem_ip[rd_addr];
    rd_mac <= mem_mac[rd_addr];
    rd_v   <= valid[rd_addr];
    if (go) begin
      key_q <= key;
    end
    if (finish) begin
      srch_mac <= rd_mac;
    end
  end

  // Search sequencer and ring pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      ptr       <= '0;
      rd_addr   <= '0;
      issue_cnt <= '0;
      srch_on   <= 1'b0;
      cmp_on    <= 1'b0;
      cmp_last  <= 1'b0;
      srch_done <= 1'b0;
      srch_hit  <= 1'b0;
    end else begin
      srch_done <= finish;
      srch_hit  <= hit;
      if (wr.en) begin
        valid[ptr] <= 1'b1;
        ptr        <= ptr_inc;
      end
      if (go) begin
        srch_on   <= 1'b1;
        cmp_on    <= 1'b0;
        cmp_last  <= 1'b0;
        rd_addr   <= ptr_dec;
        issue_cnt <= '0;
      end else if (finish) begin
        srch_on <= 1'b0;
        cmp_on  <= 1'b0;
      end else begin
        cmp_on   <= srch_on;
        cmp_last <= srch_on && (issue_cnt == LAST_IDX);
        if (srch_on) begin
          rd_addr   <= rd_addr_dec;
          issue_cnt <= issue_cnt + AW'(1);
          if (issue_cnt == LAST_IDX) begin
            srch_on <= 1'b0;
          end
        end
      end
    end
  end

  assign srch = '{done: srch_done, hit: srch_hit, mac: srch_mac};

  // A write never lands in the middle of a search
  a_no_wr_in_search: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> !srch_on && !cmp_on)
    else $error("cache write during search");

  // Done is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    srch_done |=> !srch_done)
    else $error("search done held longer than one cycle");

endmodule

`default_nettype wire

/* rtl/core/arpc_ctrl.sv */
// Command sequencer: starts cache searches, walks the ports and emits
// result words at most one per cycle. Depends on arpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arpc_ctrl #(
  parameter int NUM_PORTS = arpc_pkg::NUM_PORTS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire arpc_pkg::in_t       item,
  output logic                     busy,
  input  wire logic [1:0]          port_count,
  input  wire logic [31:0]         port_ip  [NUM_PORTS],
  input  wire logic [47:0]         port_mac [NUM_PORTS],
  output logic                     srch_go,
  output logic [31:0]              srch_key,
  input  wire arpc_pkg::srch_t     srch,
  output arpc_pkg::cache_wr_t      wr,
  output logic                     result_valid,
  output arpc_pkg::out_t           result
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WAIT_R = 3'd1;
  localparam logic [2:0] S_REQ    = 3'd2;
  localparam logic [2:0] S_WAIT_Q = 3'd3;
  localparam logic [2:0] S_LOCAL  = 3'd4;

  logic [2:0]     state, state_next;
  logic [1:0]     idx, idx_next;
  arpc_pkg::in_t  item_q, item_next;
  arpc_pkg::out_t res, res_next;
  logic           res_valid, res_valid_next;

  logic [1:0]  np;
  logic [31:0] sel_ip;
  logic [47:0] sel_mac;
  logic [31:0] in_ip;

  // Result word builders
  function automatic arpc_pkg::out_t mk_simple(input logic [2:0] kind,
                                               input logic [47:0] mac);
    arpc_pkg::out_t r;
    r              = '0;
    r.kind         = kind;
    r.last         = 1'b1;
    r.resolved_mac = mac;
    return r;
  endfunction

  function automatic arpc_pkg::out_t mk_reply(input arpc_pkg::in_t it,
                                              input logic [47:0] mac,
                                              input logic [31:0] src_ip);
    arpc_pkg::out_t r;
    r             = '0;
    r.kind        = arpc_pkg::KIND_REPLY;
    r.last        = 1'b1;
    r.out_port    = it.in_port;
    r.eth_dst_mac = it.sender_mac;
    r.arp_src_mac = mac;
    r.arp_src_ip  = src_ip;
    r.arp_dst_mac = it.sender_mac;
    r.arp_dst_ip  = it.sender_ip;
    return r;
  endfunction

  // Clamp the port count to the ports that exist
  assign np = (port_count > 2'(NUM_PORTS)) ? 2'(NUM_PORTS) : port_count;

  // Select the walked port and the ingress port
  always_comb begin
    sel_ip  = '0;
    sel_mac = '0;
    in_ip   = '0;
    for (int p = 0; p < NUM_PORTS; p++) begin
      if (idx == 2'(p)) begin
        sel_ip  = port_ip[p];
        sel_mac = port_mac[p];
      end
      if (item_q.in_port == 2'(p)) begin
        in_ip = port_ip[p];
      end
    end
  end

  assign busy     = (state != S_IDLE);
  assign srch_key = item.query_ip;

  // Next-state and result logic
  always_comb begin
    state_next     = state;
    idx_next       = idx;
    item_next      = item_q;
    res_next       = res;
    res_valid_next = 1'b0;
    srch_go        = 1'b0;
    wr             = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          item_next = item;
          case (item.cmd)
            arpc_pkg::CMD_RESOLVE: begin
              srch_go    = 1'b1;
              state_next = S_WAIT_R;
            end
            arpc_pkg::CMD_REQUEST: begin
              if (item.in_port < np) begin
                srch_go    = 1'b1;
                state_next = S_WAIT_Q;
              end else begin
                res_next       = mk_simple(arpc_pkg::KIND_NONE, '0);
                res_valid_next = 1'b1;
              end
            end
            arpc_pkg::CMD_REPLY: begin
              wr.en          = 1'b1;
              wr.ip          = item.sender_ip;
              wr.mac         = item.sender_mac;
              res_next       = mk_simple(arpc_pkg::KIND_NONE, '0);
              res_valid_next = 1'b1;
            end
            default: begin
              res_next       = mk_simple(arpc_pkg::KIND_NONE, '0);
              res_valid_next = 1'b1;
            end
          endcase
        end
      end
      S_WAIT_R: begin
        if (srch.done) begin
          if (srch.hit) begin
            res_next       = mk_simple(arpc_pkg::KIND_HIT, srch.mac);
            res_valid_next = 1'b1;
            state_next     = S_IDLE;
          end else begin
            idx_next   = '0;
            state_next = S_REQ;
          end
        end
      end
      S_REQ: begin
        // Broadcast on each present port but the ingress one, then miss
        if (idx < np) begin
          if (idx != item_q.in_port) begin
            res_next             = '0;
            res_next.kind        = arpc_pkg::KIND_REQ;
            res_next.out_port    = idx;
            res_next.eth_dst_mac = arpc_pkg::MAC_BCAST;
            res_next.arp_src_mac = sel_mac;
            res_next.arp_src_ip  = sel_ip;
            res_next.arp_dst_ip  = item_q.query_ip;
            res_valid_next       = 1'b1;
          end
          idx_next = idx + 2'd1;
        end else begin
          res_next       = mk_simple(arpc_pkg::KIND_MISS, '0);
          res_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_WAIT_Q: begin
        if (srch.done) begin
          if (srch.hit) begin
            res_next       = mk_reply(item_q, srch.mac, in_ip);
            res_valid_next = 1'b1;
            state_next     = S_IDLE;
          end else begin
            idx_next   = '0;
            state_next = S_LOCAL;
          end
        end
      end
      S_LOCAL: begin
        // Answer for the first local port owning the target, and learn it
        if (idx < np) begin
          if (sel_ip == item_q.query_ip) begin
            wr.en          = 1'b1;
            wr.ip          = item_q.query_ip;
            wr.mac         = sel_mac;
            res_next       = mk_reply(item_q, sel_mac, in_ip);
            res_valid_next = 1'b1;
            state_next     = S_IDLE;
          end else begin
            idx_next = idx + 2'd1;
          end
        end else begin
          res_next       = mk_simple(arpc_pkg::KIND_NONE, '0);
          res_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      res_valid <= res_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_q <= item_next;
    res    <= res_next;
  end

  assign result_valid = res_valid;
  assign result       = res;

  // Search completion only arrives while a search is awaited
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    srch.done |-> (state == S_WAIT_R) || (state == S_WAIT_Q))
    else $error("search done outside a wait state");

  // Leaving busy always comes with the final word
  a_busy_ends_last: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> res_valid && res.last)
    else $error("busy dropped without a final word");

  // A hit word is always the final word
  a_hit_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.kind == arpc_pkg::KIND_HIT) |-> res.last)
    else $error("hit word not marked last");

endmodule

`default_nettype wire

/* tb/arpc_checker.sv */
// Scoreboard for the ARP cache and responder: tracks configuration writes,
// predicts the result words of each accepted command and checks them in order.
// Depends on arpc_pkg.
`timescale 1ns / 1ps

module arpc_checker #(
  parameter int DEPTH = arpc_pkg::CACHE_DEPTH,
  parameter int PORTS = arpc_pkg::NUM_PORTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  arpc_pkg::in_t                   item,
  input  logic                            result_valid,
  input  arpc_pkg::out_t                  result,
  input  logic                            cfg_we,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              outstanding
);

  // Shadow configuration
  logic [1:0]  port_cnt;
  logic [31:0] local_ip[3];
  logic [47:0] local_mac[3];

  // Shadow binding ring
  logic [31:0] bind_ip[DEPTH];
  logic [47:0] bind_mac[DEPTH];
  bit          bind_ok[DEPTH];
  int unsigned wr_ptr;

  arpc_pkg::out_t due_words[$];

  // Search the ring newest first; only valid entries take part.
  function automatic bit find_binding(input logic [31:0] ip, output logic [47:0] mac);
    int idx;
    bit found;
    found = 1'b0;
    mac = '0;
    for (int k = 1; k <= DEPTH; k++) begin
      idx = (wr_ptr + DEPTH - k) % DEPTH;
      if (!found && bind_ok[idx] && bind_ip[idx] == ip) begin
        found = 1'b1;
        mac = bind_mac[idx];
      end
    end
    return found;
  endfunction

  // Overwrite the oldest slot and advance.
  function automatic void learn_binding(input logic [31:0] ip, input logic [47:0] mac);
    bind_ip[wr_ptr]  = ip;
    bind_mac[wr_ptr] = mac;
    bind_ok[wr_ptr]  = 1'b1;
    wr_ptr = (wr_ptr + 1) % DEPTH;
  endfunction

  // Work out the words one command produces and queue them.
  task automatic predict_arp_words(input arpc_pkg::in_t w);
    arpc_pkg::out_t word;
    arpc_pkg::out_t words[$];
    logic [47:0]    mac;
    bit             found;
    int             np;
    np = (port_cnt > PORTS) ? PORTS : port_cnt;
    if (w.cmd == arpc_pkg::CMD_RESOLVE) begin
      if (find_binding(w.query_ip, mac)) begin
        word = '0;
        word.kind = arpc_pkg::KIND_HIT;
        word.resolved_mac = mac;
        words.push_back(word);
      end else begin
        // broadcast on every present port but the ingress one
        for (int i = 0; i < np; i++) begin
          if (i != w.in_port) begin
            word = '0;
            word.kind        = arpc_pkg::KIND_REQ;
            word.out_port    = i[1:0];
            word.eth_dst_mac = arpc_pkg::MAC_BCAST;
            word.arp_src_mac = local_mac[i];
            word.arp_src_ip  = local_ip[i];
            word.arp_dst_ip  = w.query_ip;
            words.push_back(word);
          end
        end
        word = '0;
        word.kind = arpc_pkg::KIND_MISS;
        words.push_back(word);
      end
    end else if (w.cmd == arpc_pkg::CMD_REQUEST && w.in_port < np) begin
      found = find_binding(w.query_ip, mac);
      // fall back to the first local port that owns the address
      for (int i = 0; i < np; i++) begin
        if (!found && local_ip[i] == w.query_ip) begin
          mac = local_mac[i];
          learn_binding(w.query_ip, mac);
          found = 1'b1;
        end
      end
      word = '0;
      if (found) begin
        word.kind        = arpc_pkg::KIND_REPLY;
        word.out_port    = w.in_port;
        word.eth_dst_mac = w.sender_mac;
        word.arp_src_mac = mac;
        word.arp_src_ip  = local_ip[w.in_port];
        word.arp_dst_mac = w.sender_mac;
        word.arp_dst_ip  = w.sender_ip;
      end else begin
        word.kind = arpc_pkg::KIND_NONE;
      end
      words.push_back(word);
    end else begin
      if (w.cmd == arpc_pkg::CMD_REPLY) learn_binding(w.sender_ip, w.sender_mac);
      word = '0;
      word.kind = arpc_pkg::KIND_NONE;
      words.push_back(word);
    end
    words[words.size() - 1].last = 1'b1;
    foreach (words[j]) due_words.push_back(words[j]);
  endtask

  task automatic check_field(input string fname, input logic [47:0] exp_v,
                             input logic [47:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", fname, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic check_word(input arpc_pkg::out_t exp_w, input arpc_pkg::out_t act_w);
    check_field("kind", 48'(exp_w.kind), 48'(act_w.kind));
    check_field("last", 48'(exp_w.last), 48'(act_w.last));
    check_field("out_port", 48'(exp_w.out_port), 48'(act_w.out_port));
    check_field("eth_dst_mac", exp_w.eth_dst_mac, act_w.eth_dst_mac);
    check_field("arp_src_mac", exp_w.arp_src_mac, act_w.arp_src_mac);
    check_field("arp_src_ip", 48'(exp_w.arp_src_ip), 48'(act_w.arp_src_ip));
    check_field("arp_dst_mac", exp_w.arp_dst_mac, act_w.arp_dst_mac);
    check_field("arp_dst_ip", 48'(exp_w.arp_dst_ip), 48'(act_w.arp_dst_ip));
    check_field("resolved_mac", exp_w.resolved_mac, act_w.resolved_mac);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      port_cnt = arpc_pkg::PORT_COUNT_RESET;
      for (int p = 0; p < 3; p++) begin
        local_ip[p]  = '0;
        local_mac[p] = '0;
      end
      for (int k = 0; k < DEPTH; k++) bind_ok[k] = 1'b0;
      wr_ptr = 0;
      mismatches = 0;
      due_words.delete();
    end else begin
      // check the word on the bus against the oldest prediction
      if (result_valid) begin
        if (due_words.size() == 0) begin
          $error("unexpected result word, kind %0d", result.kind);
          mismatches++;
        end else begin
          check_word(due_words.pop_front(), result);
        end
      end
      // track register writes
      if (cfg_we) begin
        if (cfg_index == arpc_pkg::REG_PORT_COUNT) port_cnt = cfg_data[1:0];
        for (int p = 0; p < 3; p++) begin
          if (int'(cfg_index) == int'(arpc_pkg::REG_PORT0_IP) + arpc_pkg::REG_STRIDE * p)
            local_ip[p] = cfg_data[31:0];
          if (int'(cfg_index) == int'(arpc_pkg::REG_PORT0_MAC) + arpc_pkg::REG_STRIDE * p)
            local_mac[p] = cfg_data;
        end
      end
      if (start && !busy) predict_arp_words(item);
    end
    outstanding = due_words.size();
  end

endmodule

/* tb/tb_top.sv */
// Testbench top for arp_cache_responder_top: clock, reset, port setup and
// command stimulus, watchdog and verdict. Depends on arpc_pkg and arpc_checker.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [1:0] PORT_NONE   = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = arpc_pkg::CACHE_DEPTH + 2 * arpc_pkg::NUM_PORTS + 16;
  localparam int PHASE_WORDS    = 62;
  localparam int POOL_SIZE      = 24;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            start = 1'b0;
  arpc_pkg::in_t                   item = '0;
  logic                            cfg_we = 1'b0;
  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            busy;
  logic                            result_valid;
  arpc_pkg::out_t                  result;
  int                              mismatches;
  int                              outstanding;
  int                              quiet_cycles = 0;

  // Stimulus-side view of the ports, used to aim targets
  logic [1:0]  cur_count = arpc_pkg::PORT_COUNT_RESET;
  logic [31:0] cur_ip[3] = '{default: '0};
  logic [31:0] learned_ips[$];
  int          idle_pct = 0;

  always #10 clk = ~clk;

  arp_cache_responder_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  arpc_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // Stop a hung run: count cycles with no traffic at all
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic arpc_pkg::in_t arp_word(input logic [1:0] cmd, input logic [31:0] tip,
                                             input logic [31:0] sip, input logic [47:0] smac,
                                             input logic [1:0] port);
    arpc_pkg::in_t w;
    w.cmd        = cmd;
    w.query_ip   = tip;
    w.sender_ip  = sip;
    w.sender_mac = smac;
    w.in_port    = port;
    return w;
  endfunction

  function automatic logic [47:0] rand_mac();
    return {16'($urandom()), $urandom()};
  endfunction

  // Mostly addresses the cache or a port knows, sometimes fresh ones
  function automatic logic [31:0] pick_ip();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && learned_ips.size() > 0)
      return learned_ips[$urandom_range(0, learned_ips.size() - 1)];
    if (r < 65) return cur_ip[$urandom_range(0, 2)];
    return $urandom();
  endfunction

  function automatic arpc_pkg::in_t random_arp_word();
    arpc_pkg::in_t w;
    int            r;
    w = arp_word(arpc_pkg::CMD_RESOLVE, pick_ip(), pick_ip(), rand_mac(),
                 2'($urandom_range(0, 3)));
    // favor ingress ports that are present
    if (cur_count != 0 && $urandom_range(0, 99) < 75)
      w.in_port = 2'($urandom_range(0, cur_count - 1));
    r = $urandom_range(0, 99);
    if (r < 38) w.cmd = arpc_pkg::CMD_RESOLVE;
    else if (r < 70) w.cmd = arpc_pkg::CMD_REQUEST;
    else if (r < 94) w.cmd = arpc_pkg::CMD_REPLY;
    else w.cmd = CMD_UNKNOWN;
    if (w.cmd == arpc_pkg::CMD_REPLY && $urandom_range(0, 1) == 0) w.sender_ip = $urandom();
    return w;
  endfunction

  // Present one command word and hold it until taken, then maybe idle
  task automatic send_word(input arpc_pkg::in_t w);
    @(negedge clk);
    start <= 1'b1;
    item  <= w;
    do @(posedge clk); while (busy);
    if (w.cmd == arpc_pkg::CMD_REPLY) begin
      learned_ips.push_back(w.sender_ip);
      if (learned_ips.size() > POOL_SIZE) void'(learned_ips.pop_front());
    end
    if ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1, 18) - 1) @(negedge clk);
    end
  endtask

  // Drop start and wait until every predicted word has come out
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0 || busy) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [arpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [arpc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  // Reprogram all port registers while the block is idle
  task automatic set_ports(input logic [1:0] cnt,
                           input logic [31:0] ip0, input logic [47:0] mac0,
                           input logic [31:0] ip1, input logic [47:0] mac1,
                           input logic [31:0] ip2, input logic [47:0] mac2);
    logic [31:0] ips[3];
    logic [47:0] macs[3];
    ips  = '{ip0, ip1, ip2};
    macs = '{mac0, mac1, mac2};
    drain();
    write_reg(arpc_pkg::REG_PORT_COUNT, 48'(cnt));
    for (int p = 0; p < 3; p++) begin
      write_reg(arpc_pkg::CFG_IDX_W'(int'(arpc_pkg::REG_PORT0_IP) + arpc_pkg::REG_STRIDE * p),
                48'(ips[p]));
      write_reg(arpc_pkg::CFG_IDX_W'(int'(arpc_pkg::REG_PORT0_MAC) + arpc_pkg::REG_STRIDE * p),
                macs[p]);
      cur_ip[p] = ips[p];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_count = cnt;
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed: reset ports (one port, address zero)
    send_word(arp_word(arpc_pkg::CMD_RESOLVE, 32'h0, 32'h0, 48'h0, PORT_NONE));
    send_word(arp_word(CMD_UNKNOWN, '1, '1, '1, PORT_NONE));
    send_word(arp_word(arpc_pkg::CMD_REQUEST, 32'h0, 32'h1, 48'h0200_0000_0001, PORT_NONE));
    send_word(arp_word(arpc_pkg::CMD_REQUEST, 32'h0, 32'h1, 48'h0200_0000_0001, 2'd1));
    send_word(arp_word(arpc_pkg::CMD_REQUEST, 32'h0, 32'h0a00_0001, 48'h0200_0000_0001,
                       2'd0));
    send_word(arp_word(arpc_pkg::CMD_RESOLVE, 32'h0, 32'h0, 48'h0, 2'd0));
    send_word(arp_word(arpc_pkg::CMD_REPLY, 32'h0, '1, '1, 2'd0));
    send_word(arp_word(arpc_pkg::CMD_RESOLVE, '1, 32'h0, 48'h0, 2'd0));
    send_word(arp_word(arpc_pkg::CMD_REQUEST, 32'h1234_5678, 32'h5, 48'h5, 2'd0));
    send_word(arp_word(arpc_pkg::CMD_RESOLVE, 32'h1234_5678, 32'h0, 48'h0, 2'd0));

    // Directed: three ports, broadcasts, local answers, newest binding wins
    set_ports(2'd3, 32'hc0a8_0001, 48'h0200_0000_0a01, 32'hc0a8_0002, 48'h0200_0000_0a02,
              32'hc0a8_0003, 48'h0200_0000_0a03);
    send_word(arp_word(arpc_pkg::CMD_RESOLVE, 32'h0a0a_0a0a, 32'h0, 48'h0, PORT_NONE));
    send_word(arp_word(arpc_pkg::CMD_RESOLVE, 32'h0a0a_0a0a, 32'h0, 48'h0, 2'd1));
    send_word(arp_word(arpc_pkg::CMD_REQUEST, 32'hc0a8_0001, 32'h0a00_0009,
                       48'h0a0b_0c0d_0e0f, 2'd2));
    send_word(arp_word(arpc_pkg::CMD_RESOLVE, 32'hc0a8_0001, 32'h0, 48'h0, 2'd0));
    send_word(arp_word(arpc_pkg::CMD_REPLY, 32'h0, 32'h0a0a_0a0a, 48'h1111_2222_3333,
                       2'd0));
    send_word(arp_word(arpc_pkg::CMD_REPLY, 32'h0, 32'h0a0a_0a0a, 48'h4444_5555_6666,
                       2'd2));
    send_word(arp_word(arpc_pkg::CMD_RESOLVE, 32'h0a0a_0a0a, 32'h0, 48'h0, 2'd0));
    send_word(arp_word(arpc_pkg::CMD_REQUEST, 32'h0a0a_0a0a, 32'h0a00_0007,
                       48'h0000_0000_0007, 2'd1));

    // Random phases, each with its own port setup and idle density
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_ports(2'd2, $urandom(), rand_mac(), $urandom(), rand_mac(),
                     $urandom(), rand_mac());
        1: set_ports(2'd0, $urandom(), rand_mac(), $urandom(), rand_mac(),
                     $urandom(), rand_mac());
        2: set_ports(2'd3, 32'h0, 48'h0, '1, '1, '1, rand_mac());
        3: set_ports(2'd1, $urandom(), rand_mac(), $urandom(), rand_mac(),
                     $urandom(), rand_mac());
        default: set_ports(2'd3, $urandom(), rand_mac(), $urandom(), rand_mac(),
                           $urandom(), rand_mac());
      endcase
      case (ph)
        0: idle_pct = 40;
        1: idle_pct = 25;
        2: idle_pct = 50;
        3: idle_pct = 15;
        default: idle_pct = 0;
      endcase
      repeat (PHASE_WORDS) send_word(random_arp_word());
    end

    // Let the last words come out, then give the verdict
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
